FILE: src/gain_command_parser_macros.svh
// Assertion helpers of the gain command parser, used by gcp_fixed_conv.
// Each macro expands to one labelled concurrent assertion on the rising clock edge,
// switched off while reset is high.
`ifndef GAIN_COMMAND_PARSER_MACROS_SVH
`define GAIN_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication.
`define GCP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gain command parser check failed");

// Next-cycle implication.
`define GCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gain command parser check failed");

`endif

FILE: src/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg
// Constants, character codes and shared types of the gain command parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcp_pkg;

   localparam int BYTE_W          = 8;
   localparam int INDEX_W         = 4;
   localparam int VALUE_W         = 32;
   localparam int MAX_FRAME       = 64;
   localparam int FRAC_BITS       = 16;
   localparam int MAX_FRAC_DIGITS = 5;

   localparam int LEN_W       = $clog2(MAX_FRAME + 1);
   localparam int DIGIT_CNT_W = 3;

   // Any integer part above the cap saturates the result for either sign, so the
   // register only has to tell the cap apart from the values below it.
   localparam int INT_CAP = (1 << (VALUE_W - 1 - FRAC_BITS)) + 1;
   localparam int INT_W   = $clog2(INT_CAP + 1);
   localparam int FRAC_W  = $clog2(10 ** MAX_FRAC_DIGITS);

   // The fraction is normalised to MAX_FRAC_DIGITS digits and then rounded as
   // X / DIV_DEN, X = f * 2^X_SHIFT + 5^digits, DIV_DEN = 2 * 5^digits.
   localparam int     X_SHIFT   = FRAC_BITS - MAX_FRAC_DIGITS + 1;
   localparam longint FIVE_POW  = longint'(5 ** MAX_FRAC_DIGITS);
   localparam longint DIV_DEN   = 2 * FIVE_POW;
   localparam longint X_MAX     = (longint'(10 ** MAX_FRAC_DIGITS) - 1)
                                  * (longint'(1) << X_SHIFT) + FIVE_POW;
   localparam int     X_W       = $clog2(X_MAX + 1);
   localparam int     REC_SHIFT = X_W + 3;
   localparam longint REC_MUL   = (longint'(1) << REC_SHIFT) / DIV_DEN;
   localparam int     REC_W     = $clog2(REC_MUL + 1);
   localparam int     PROD_W    = X_W + REC_W;
   localparam int     DEN_W     = $clog2(DIV_DEN + 1);
   localparam int     Q_W       = FRAC_BITS + 1;
   localparam int     MAG_W     = INT_W + FRAC_BITS + 1;

   localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_BANG   = 8'h21;
   localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_POINT  = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_ONE    = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_THREE  = 8'h33;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
   localparam logic [BYTE_W-1:0] CHAR_K      = 8'h4B;
   localparam logic [BYTE_W-1:0] CHAR_D      = 8'h44;

   // Everything the conversion needs from a frame at its closing '!'.
   typedef struct packed {
      logic                   write_valid;
      logic [INDEX_W-1:0]     gain_index;
      logic                   error;
      logic                   negative;
      logic [INT_W-1:0]       integer_part;
      logic [FRAC_W-1:0]      fraction_part;
      logic [DIGIT_CNT_W-1:0] fraction_digits;
   } frame_snap_type;

   // Fields that ride along the conversion pipeline unchanged.
   typedef struct packed {
      logic               write_valid;
      logic [INDEX_W-1:0] gain_index;
      logic               error;
      logic               negative;
      logic [INT_W-1:0]   integer_part;
   } conv_meta_type;

endpackage

FILE: src/gcp_parser.sv
// ----------------------------------------------------------------------------
// gcp_parser
// Byte-level frame parser: tracks the gain name and builds the decimal number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcp_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [gcp_pkg::BYTE_W-1:0]  rx_byte,
   output logic                        snap_valid,
   output gcp_pkg::frame_snap_type     snap
);
   import gcp_pkg::*;

   logic [BYTE_W-1:0]      first_ff, first_in;
   logic [BYTE_W-1:0]      second_ff, second_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   seen_eq_ff, seen_eq_in;
   logic                   started_ff, started_in;
   logic                   neg_ff, neg_in;
   logic                   point_ff, point_in;
   logic [DIGIT_CNT_W-1:0] fdig_ff, fdig_in;
   logic [INT_W-1:0]       int_ff, int_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;
   logic                   bad_ff, bad_in;

   logic                   is_bang;
   logic                   is_digit;
   logic [3:0]             digit;
   logic [INT_W+3:0]       int_next;
   logic [FRAC_W+3:0]      frac_next;
   logic [BYTE_W-1:0]      eff_first;
   logic [BYTE_W-1:0]      eff_second;
   logic [1:0]             kind;
   logic [1:0]             loop_sel;
   logic                   kind_ok;
   logic                   loop_ok;

   assign is_bang  = (rx_byte == CHAR_BANG);
   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign digit    = 4'(rx_byte - CHAR_ZERO);
   assign int_next = (INT_W+4)'(int_ff) * (INT_W+4)'(10) + (INT_W+4)'(digit);
   assign frac_next = (FRAC_W+4)'(frac_ff) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);

   always_comb begin
      first_in   = first_ff;
      second_in  = second_ff;
      len_in     = len_ff;
      seen_eq_in = seen_eq_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      point_in   = point_ff;
      fdig_in    = fdig_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      bad_in     = bad_ff;
      if (accept) begin
         if (is_bang) begin
            first_in   = '0;
            second_in  = '0;
            len_in     = '0;
            seen_eq_in = 1'b0;
            started_in = 1'b0;
            neg_in     = 1'b0;
            point_in   = 1'b0;
            fdig_in    = '0;
            int_in     = '0;
            frac_in    = '0;
            bad_in     = 1'b0;
         end else begin
            if (len_ff < LEN_W'(MAX_FRAME)) begin
               len_in = len_ff + 1'b1;
            end
            if (len_ff == '0) begin
               first_in = rx_byte;
            end else if (len_ff == LEN_W'(1)) begin
               second_in = rx_byte;
            end
            // Every '=' starts the number afresh, forgetting earlier bad characters.
            if (rx_byte == CHAR_EQUALS) begin
               seen_eq_in = 1'b1;
               started_in = 1'b0;
               neg_in     = 1'b0;
               point_in   = 1'b0;
               fdig_in    = '0;
               int_in     = '0;
               frac_in    = '0;
               bad_in     = 1'b0;
            end else if (seen_eq_ff) begin
               started_in = 1'b1;
               priority if (rx_byte == CHAR_MINUS && !started_ff) begin
                  neg_in = 1'b1;
               end else if (rx_byte == CHAR_POINT) begin
                  if (point_ff) begin
                     bad_in = 1'b1;
                  end else begin
                     point_in = 1'b1;
                  end
               end else if (is_digit) begin
                  if (point_ff) begin
                     // Digits beyond the kept precision are checked but dropped.
                     if (fdig_ff < DIGIT_CNT_W'(MAX_FRAC_DIGITS)) begin
                        frac_in = FRAC_W'(frac_next);
                        fdig_in = fdig_ff + 1'b1;
                     end
                  end else begin
                     int_in = (int_next > (INT_W+4)'(INT_CAP)) ? INT_W'(INT_CAP)
                                                               : INT_W'(int_next);
                  end
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= '0;
         second_ff  <= '0;
         len_ff     <= '0;
         seen_eq_ff <= 1'b0;
         started_ff <= 1'b0;
         neg_ff     <= 1'b0;
         point_ff   <= 1'b0;
         fdig_ff    <= '0;
         int_ff     <= '0;
         frac_ff    <= '0;
         bad_ff     <= 1'b0;
      end else begin
         first_ff   <= first_in;
         second_ff  <= second_in;
         len_ff     <= len_in;
         seen_eq_ff <= seen_eq_in;
         started_ff <= started_in;
         neg_ff     <= neg_in;
         point_ff   <= point_in;
         fdig_ff    <= fdig_in;
         int_ff     <= int_in;
         frac_ff    <= frac_in;
         bad_ff     <= bad_in;
      end
   end

   // A '!' in the first or second place of a frame is itself the name byte.
   assign eff_first  = (len_ff == '0) ? rx_byte : first_ff;
   assign eff_second = (len_ff == LEN_W'(1)) ? rx_byte : second_ff;

   always_comb begin
      kind    = 2'd0;
      kind_ok = 1'b1;
      priority if (eff_first == CHAR_P) begin
         kind = 2'd0;
      end else if (eff_first == CHAR_K) begin
         kind = 2'd1;
      end else if (eff_first == CHAR_D) begin
         kind = 2'd2;
      end else begin
         kind_ok = 1'b0;
      end
   end

   assign loop_ok  = (eff_second >= CHAR_ONE) && (eff_second <= CHAR_THREE);
   assign loop_sel = 2'(eff_second - CHAR_ONE);

   assign snap_valid = accept && is_bang;

   always_comb begin
      snap.write_valid     = kind_ok && loop_ok;
      snap.gain_index      = (kind_ok && loop_ok)
                             ? INDEX_W'(4'(kind) * 4'd3 + 4'(loop_sel)) : '0;
      snap.error           = bad_ff || !seen_eq_ff || (len_ff >= LEN_W'(MAX_FRAME));
      snap.negative        = neg_ff;
      snap.integer_part    = int_ff;
      snap.fraction_part   = frac_ff;
      snap.fraction_digits = fdig_ff;
   end

endmodule

FILE: src/gcp_fixed_conv.sv
// ----------------------------------------------------------------------------
// gcp_fixed_conv
// Pipelined conversion of a parsed frame to a saturated signed fixed-point word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gain_command_parser_macros.svh"

module gcp_fixed_conv (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         snap_valid,
   input  gcp_pkg::frame_snap_type      snap,
   output logic                         in_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_write_valid,
   output logic [gcp_pkg::INDEX_W-1:0]  rsp_gain_index,
   output logic signed [gcp_pkg::VALUE_W-1:0] rsp_gain_value,
   output logic                         rsp_parse_error
);
   import gcp_pkg::*;

   // Stage A: captured frame.
   logic            a_valid_ff;
   frame_snap_type  a_snap_ff;
   // Stage B: normalised numerator.
   logic            b_valid_ff;
   conv_meta_type   b_meta_ff;
   logic [X_W-1:0]  b_x_ff;
   // Stage C: reciprocal product.
   logic            c_valid_ff;
   conv_meta_type   c_meta_ff;
   logic [X_W-1:0]  c_x_ff;
   logic [PROD_W-1:0] c_prod_ff;
   // Stage D: rounded fraction.
   logic            d_valid_ff;
   conv_meta_type   d_meta_ff;
   logic [Q_W-1:0]  d_q_ff;
   // Output register.
   logic            e_valid_ff;
   logic            e_write_valid_ff;
   logic [INDEX_W-1:0] e_index_ff;
   logic [VALUE_W-1:0] e_value_ff;
   logic            e_error_ff;

   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

   logic [FRAC_W-1:0]   scale;
   logic [FRAC_W-1:0]   frac_norm;
   logic [X_W-1:0]      x_value;
   conv_meta_type       a_meta;
   logic [Q_W-1:0]      q_est;
   logic [X_W:0]        q_times_den;
   logic [X_W:0]        rem;
   logic [Q_W-1:0]      q_round;
   logic [MAG_W-1:0]    mag;
   logic [MAG_W-1:0]    mag_sat;
   logic [VALUE_W-1:0]  value;

   function automatic logic [FRAC_W-1:0] frac_scale(input logic [DIGIT_CNT_W-1:0] n);
      logic [FRAC_W-1:0] s;
      s = FRAC_W'(1);
      for (int i = 0; i < 7; i++) begin
         if (i < MAX_FRAC_DIGITS - int'(n)) begin
            s = FRAC_W'(s * FRAC_W'(10));
         end
      end
      return s;
   endfunction

   assign rdy_e    = !e_valid_ff || !rsp_stall;
   assign rdy_d    = !d_valid_ff || rdy_e;
   assign rdy_c    = !c_valid_ff || rdy_d;
   assign rdy_b    = !b_valid_ff || rdy_c;
   assign rdy_a    = !a_valid_ff || rdy_b;
   assign in_ready = rdy_a;

   // Stage A to B: scale the fraction to the full digit count, then form X.
   assign scale     = frac_scale(a_snap_ff.fraction_digits);
   assign frac_norm = FRAC_W'((2*FRAC_W)'(a_snap_ff.fraction_part) * (2*FRAC_W)'(scale));
   assign x_value   = (X_W'(frac_norm) << X_SHIFT) + X_W'(FIVE_POW);

   always_comb begin
      a_meta.write_valid  = a_snap_ff.write_valid;
      a_meta.gain_index   = a_snap_ff.gain_index;
      a_meta.error        = a_snap_ff.error;
      a_meta.negative     = a_snap_ff.negative;
      a_meta.integer_part = a_snap_ff.integer_part;
   end

   // Stage C to D: the reciprocal estimate is at most one low; one compare fixes it.
   assign q_est       = Q_W'(c_prod_ff >> REC_SHIFT);
   assign q_times_den = (X_W+1)'((Q_W+DEN_W)'(q_est) * (Q_W+DEN_W)'(DIV_DEN));
   assign rem         = (X_W+1)'(c_x_ff) - q_times_den;
   assign q_round     = q_est + Q_W'(rem >= (X_W+1)'(DIV_DEN));

   // Stage D to output: assemble, saturate and apply the sign.
   assign mag = (MAG_W'(d_meta_ff.integer_part) << FRAC_BITS) + MAG_W'(d_q_ff);

   always_comb begin
      if (d_meta_ff.negative) begin
         mag_sat = (mag > MAG_W'(64'h8000_0000)) ? MAG_W'(64'h8000_0000) : mag;
         value   = VALUE_W'(0) - VALUE_W'(mag_sat);
      end else begin
         mag_sat = (mag > MAG_W'(64'h7FFF_FFFF)) ? MAG_W'(64'h7FFF_FFFF) : mag;
         value   = VALUE_W'(mag_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            a_valid_ff <= snap_valid;
         end
         if (rdy_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (rdy_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (rdy_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (rdy_e) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_snap_ff <= snap;
      end
      if (rdy_b) begin
         b_meta_ff <= a_meta;
         b_x_ff    <= x_value;
      end
      if (rdy_c) begin
         c_meta_ff <= b_meta_ff;
         c_x_ff    <= b_x_ff;
         c_prod_ff <= PROD_W'(PROD_W'(b_x_ff) * PROD_W'(REC_MUL));
      end
      if (rdy_d) begin
         d_meta_ff <= c_meta_ff;
         d_q_ff    <= q_round;
      end
      if (rdy_e) begin
         e_write_valid_ff <= d_meta_ff.write_valid;
         e_index_ff       <= d_meta_ff.gain_index;
         e_error_ff       <= d_meta_ff.error;
         e_value_ff       <= d_meta_ff.error ? '0 : value;
      end
   end

   assign rsp_valid       = e_valid_ff;
   assign rsp_write_valid = e_write_valid_ff;
   assign rsp_gain_index  = e_index_ff;
   assign rsp_gain_value  = $signed(e_value_ff);
   assign rsp_parse_error = e_error_ff;

   `GCP_ASSERT_IMPL(a_error_gives_zero, rsp_valid && rsp_parse_error, rsp_gain_value == '0)
   `GCP_ASSERT_IMPL(a_unknown_gain_index, rsp_valid && !rsp_write_valid, rsp_gain_index == '0)
   `GCP_ASSERT_IMPL(a_round_in_range, d_valid_ff, d_q_ff <= Q_W'(1 << FRAC_BITS))
   `GCP_ASSERT_IMPL(a_stall_only_when_full, !in_ready,
                    a_valid_ff && b_valid_ff && c_valid_ff && d_valid_ff && e_valid_ff)

endmodule

FILE: src/gain_command_parser.sv
// ----------------------------------------------------------------------------
// gain_command_parser
// Parses ASCII gain write frames and emits one fixed-point write command per '!'.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle. Frames have the form
// letter, loop digit, '=', signed decimal number, '!'; each '!' word yields one
// command word, presented on the rsp_ channel after the conversion pipeline,
// carrying the gain index, the value in signed Q16.16 (saturated, zero on a
// malformed frame) and an error flag. Number parsing is done in the byte-accept
// cycle; the rounding of the fraction runs in a five-register conversion pipeline,
// and req_stall is raised only when that pipeline is full and its output word is
// stalled, so bytes flow at one per cycle otherwise.
`timescale 1ns / 1ps

module gain_command_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gcp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_write_valid,
   output logic [gcp_pkg::INDEX_W-1:0]  rsp_gain_index,
   output logic signed [gcp_pkg::VALUE_W-1:0] rsp_gain_value,
   output logic                         rsp_parse_error
);
   import gcp_pkg::*;

   logic           accept;
   logic           in_ready;
   logic           snap_valid;
   frame_snap_type snap;

   assign req_stall = !in_ready;
   assign accept    = req_valid && in_ready;

   gcp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   gcp_fixed_conv u_conv (
      .clock           (clock),
      .reset           (reset),
      .snap_valid      (snap_valid),
      .snap            (snap),
      .in_ready        (in_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write_valid (rsp_write_valid),
      .rsp_gain_index  (rsp_gain_index),
      .rsp_gain_value  (rsp_gain_value),
      .rsp_parse_error (rsp_parse_error)
   );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gain command parser.
// ----------------------------------------------------------------------------
// Bytes are fed one word at a time on the req_ channel. A parser model in this
// file follows each accepted byte and, on every '!', queues the write command
// that the block must produce. The rsp_ monitor checks each command word in
// order, field by field. A short table of hand-written frames comes first, then
// random frames, mostly well formed, with noise and broken frames mixed in.
// Both sides insert random gaps, and one long receiver hold-off is used to fill
// the conversion pipeline and push back on the byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import gcp_pkg::*;

   localparam int          RANDOM_BYTES = 1150;
   localparam int          LONG_HOLD    = 150;
   localparam int          HOLD_FRAME   = 40;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam longint      WHOLE_CAP    = 64'd16777216;
   localparam logic [7:0]  PAD_CHAR     = "x";

   typedef enum int {KIND_P, KIND_K, KIND_D, KIND_NONE} gain_kind_type;
   typedef enum bit {CHECK_PREDICTED, CHECK_TYPED} row_check_type;

   typedef struct packed {
      logic               write_valid;
      logic [INDEX_W-1:0] gain_index;
      logic [VALUE_W-1:0] gain_value;
      logic               parse_error;
   } gain_write_type;

   typedef struct {
      string          text;
      int             pad;
      row_check_type  check;
      gain_write_type typed;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [BYTE_W-1:0]         req_rx_byte;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_write_valid;
   logic [INDEX_W-1:0]        rsp_gain_index;
   logic signed [VALUE_W-1:0] rsp_gain_value;
   logic                      rsp_parse_error;

   gain_write_type pending_writes[$];
   logic [7:0]     frame_buf[$];
   int             errors = 0;
   int             cycle_count = 0;
   bit             no_idle = 1'b0;
   bit             hold_request = 1'b0;
   bit             hold_active = 1'b0;

   // Parser model state.
   logic [7:0]      lead_char;
   logic [7:0]      loop_char;
   int unsigned     frame_len;
   bit              got_equals;
   bit              digits_begun;
   bit              minus_seen;
   bit              point_seen;
   bit              frame_bad;
   int unsigned     frac_count;
   longint unsigned whole_part;
   longint unsigned frac_part;

   stim_row_type directed_rows[$] = '{
      '{"P1=0!",           0,  CHECK_TYPED,     '{1'b1, 4'd0, 32'h0000_0000, 1'b0}},
      '{"P1=0.5!",         0,  CHECK_TYPED,     '{1'b1, 4'd0, 32'h0000_8000, 1'b0}},
      '{"K2=-32768!",      0,  CHECK_TYPED,     '{1'b1, 4'd4, 32'h8000_0000, 1'b0}},
      '{"P3=99999999!",    0,  CHECK_TYPED,     '{1'b1, 4'd2, 32'h7FFF_FFFF, 1'b0}},
      '{"D1=-99999999!",   0,  CHECK_TYPED,     '{1'b1, 4'd6, 32'h8000_0000, 1'b0}},
      '{"D3=32767.99999!", 0,  CHECK_PREDICTED, '0},
      '{"D3=-0!",          0,  CHECK_TYPED,     '{1'b1, 4'd8, 32'h0000_0000, 1'b0}},
      '{"D3=-0.00001!",    0,  CHECK_PREDICTED, '0},
      '{"K3=0.1234567!",   0,  CHECK_PREDICTED, '0},
      '{"!",               0,  CHECK_TYPED,     '{1'b0, 4'd0, 32'h0000_0000, 1'b1}},
      '{"P!",              0,  CHECK_TYPED,     '{1'b0, 4'd0, 32'h0000_0000, 1'b1}},
      '{"X1=5!",           0,  CHECK_PREDICTED, '0},
      '{"P4=1!",           0,  CHECK_PREDICTED, '0},
      '{"K1 12!",          0,  CHECK_TYPED,     '{1'b1, 4'd3, 32'h0000_0000, 1'b1}},
      '{"P1=3=-2.5!",      0,  CHECK_PREDICTED, '0},
      '{"P1=a=7!",         0,  CHECK_PREDICTED, '0},
      '{"P1=1!",           59, CHECK_PREDICTED, '0},
      '{"P1=1!",           60, CHECK_TYPED,     '{1'b1, 4'd0, 32'h0000_0000, 1'b1}},
      '{"D2=1.2.3!",       0,  CHECK_TYPED,     '{1'b1, 4'd7, 32'h0000_0000, 1'b1}},
      '{"P1=12x!",         0,  CHECK_TYPED,     '{1'b1, 4'd0, 32'h0000_0000, 1'b1}},
      '{"P1=5-!",          0,  CHECK_TYPED,     '{1'b1, 4'd0, 32'h0000_0000, 1'b1}},
      '{"P1=\377!",        0,  CHECK_TYPED,     '{1'b1, 4'd0, 32'h0000_0000, 1'b1}},
      '{"P2=!",            0,  CHECK_TYPED,     '{1'b1, 4'd1, 32'h0000_0000, 1'b0}},
      '{"P2=-!",           0,  CHECK_TYPED,     '{1'b1, 4'd1, 32'h0000_0000, 1'b0}},
      '{"P2=.!",           0,  CHECK_TYPED,     '{1'b1, 4'd1, 32'h0000_0000, 1'b0}}
   };

   gain_command_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write_valid (rsp_write_valid),
      .rsp_gain_index  (rsp_gain_index),
      .rsp_gain_value  (rsp_gain_value),
      .rsp_parse_error (rsp_parse_error)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_number_state();
      digits_begun = 1'b0;
      minus_seen   = 1'b0;
      point_seen   = 1'b0;
      frame_bad    = 1'b0;
      frac_count   = 0;
      whole_part   = 0;
      frac_part    = 0;
   endfunction

   function automatic void clear_frame_state();
      lead_char  = '0;
      loop_char  = '0;
      frame_len  = 0;
      got_equals = 1'b0;
      clear_number_state();
   endfunction

   // Fraction is rounded to nearest with ties up, then the magnitude saturates
   // according to the sign before it is negated.
   function automatic logic [VALUE_W-1:0] fixed_value();
      longint unsigned mag;
      longint unsigned den;
      logic [VALUE_W-1:0] low_bits;
      mag = whole_part << FRAC_BITS;
      if (frac_count != 0) begin
         den = 1;
         repeat (frac_count) den = den * 10;
         mag = mag + ((frac_part << FRAC_BITS) + den / 2) / den;
      end
      if (minus_seen) begin
         if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
         low_bits = mag[VALUE_W-1:0];
         return -low_bits;
      end
      if (mag > 64'h7FFF_FFFF)
         mag = 64'h7FFF_FFFF;
      return mag[VALUE_W-1:0];
   endfunction

   function automatic bit parse_step(input logic [7:0] b, output gain_write_type cmd);
      gain_kind_type kind;
      bit            bad;
      cmd = '0;
      if (frame_len == 0)
         lead_char = b;
      else if (frame_len == 1)
         loop_char = b;

      if (b == CHAR_BANG) begin
         case (lead_char)
            CHAR_P:  kind = KIND_P;
            CHAR_K:  kind = KIND_K;
            CHAR_D:  kind = KIND_D;
            default: kind = KIND_NONE;
         endcase
         bad = frame_bad || !got_equals || frame_len >= MAX_FRAME;
         if (kind != KIND_NONE && loop_char >= CHAR_ONE && loop_char <= CHAR_THREE) begin
            cmd.write_valid = 1'b1;
            cmd.gain_index  = 4'(3 * int'(kind) + int'(loop_char - CHAR_ONE));
         end
         cmd.gain_value  = bad ? '0 : fixed_value();
         cmd.parse_error = bad;
         clear_frame_state();
         return 1'b1;
      end

      if (frame_len < MAX_FRAME)
         frame_len++;

      if (b == CHAR_EQUALS) begin
         got_equals = 1'b1;
         clear_number_state();
      end else if (got_equals) begin
         if (b == CHAR_MINUS && !digits_begun) begin
            minus_seen = 1'b1;
         end else if (b == CHAR_POINT) begin
            if (point_seen)
               frame_bad = 1'b1;
            else
               point_seen = 1'b1;
         end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            if (point_seen) begin
               if (frac_count < MAX_FRAC_DIGITS) begin
                  frac_part = frac_part * 10 + (b - CHAR_ZERO);
                  frac_count++;
               end
            end else begin
               whole_part = whole_part * 10 + (b - CHAR_ZERO);
               if (whole_part > WHOLE_CAP)
                  whole_part = WHOLE_CAP;
            end
         end else begin
            frame_bad = 1'b1;
         end
         digits_begun = 1'b1;
      end
      return 1'b0;
   endfunction

   // Mostly back to back, now and then a short gap, rarely a long one.
   function automatic int idle_len();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [7:0] gain_letter();
      case ($urandom_range(0, 2))
         0:       return CHAR_P;
         1:       return CHAR_K;
         default: return CHAR_D;
      endcase
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Offers one byte, waits for it to be taken, then updates the model.
   task automatic feed_byte(input logic [7:0] b, input bit use_typed,
                            input gain_write_type typed);
      gain_write_type cmd;
      int             gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (parse_step(b, cmd))
         pending_writes.push_back(use_typed ? typed : cmd);
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_writes();
      while (pending_writes.size() != 0)
         @(posedge clock);
   endtask

   task automatic build_random_frame();
      int         shape;
      int         int_len;
      int         frac_len;
      logic [7:0] num[$];
      frame_buf.delete();
      shape = $urandom_range(0, 99);
      if (shape < 6) begin
         repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      frame_buf.push_back($urandom_range(0, 9) != 0 ? gain_letter()
                                                  : 8'($urandom_range(0, 255)));
      frame_buf.push_back($urandom_range(0, 9) != 0 ? CHAR_ONE + 8'($urandom_range(0, 2))
                                                  : 8'($urandom_range(0, 255)));
      if (shape >= 95)
         repeat ($urandom_range(55, 70)) frame_buf.push_back(PAD_CHAR);
      if (shape >= 88 && shape < 95) begin
         // An earlier number that a later '=' must discard.
         frame_buf.push_back(CHAR_EQUALS);
         repeat ($urandom_range(0, 4)) frame_buf.push_back(random_digit());
         if ($urandom_range(0, 1) == 1)
            frame_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (shape >= 10)
         frame_buf.push_back(CHAR_EQUALS);

      if ($urandom_range(0, 99) < 35)
         num.push_back(CHAR_MINUS);
      int_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 5);
      repeat (int_len) num.push_back(random_digit());
      if ($urandom_range(0, 99) < 60) begin
         num.push_back(CHAR_POINT);
         frac_len = $urandom_range(0, 8);
         repeat (frac_len) num.push_back(random_digit());
      end
      if (shape >= 10 && shape < 22) begin
         if ($urandom_range(0, 2) == 0)
            num.insert($urandom_range(0, num.size()), CHAR_POINT);
         else
            num.insert($urandom_range(0, num.size()), 8'($urandom_range(0, 255)));
      end
      foreach (num[i])
         frame_buf.push_back(num[i]);
      frame_buf.push_back(CHAR_BANG);
   endtask

   initial begin : stimulus
      stim_row_type row;
      int           sent;
      int           frame_no;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      clear_frame_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (int i = 0; i < row.text.len(); i++) begin
            if (i == 2)
               repeat (row.pad) feed_byte(PAD_CHAR, 1'b0, '0);
            feed_byte(row.text[i], row.check == CHECK_TYPED, row.typed);
         end
      end
      go_idle();
      wait_for_writes();

      sent = 0;
      frame_no = 0;
      while (sent < RANDOM_BYTES) begin
         if (frame_no % 20 == 0)
            no_idle = ($urandom_range(0, 4) == 0);
         if (frame_no == HOLD_FRAME) begin
            // Keep offering words while the result side is held off, so the
            // conversion pipeline fills and the byte stream is pushed back.
            go_idle();
            hold_request = 1'b1;
            while (!hold_active)
               @(posedge clock);
            no_idle = 1'b1;
            repeat (40) feed_byte(CHAR_BANG, 1'b0, '0);
            no_idle = 1'b0;
            go_idle();
            wait_for_writes();
         end
         build_random_frame();
         foreach (frame_buf[i])
            feed_byte(frame_buf[i], 1'b0, '0);
         sent += frame_buf.size();
         frame_no++;
      end

      go_idle();
      wait_for_writes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_writes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : result_sink
      int open_len;
      int stall_len;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall   <= 1'b1;
            hold_active = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active  = 1'b0;
            hold_request = 1'b0;
         end else begin
            open_len  = $urandom_range(1, 20);
            stall_len = idle_len();
            rsp_stall <= 1'b0;
            repeat (open_len) @(posedge clock);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : check_writes
      gain_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("write command with none expected");
            errors++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_write_valid !== want.write_valid) begin
               $error("write_valid: expected %0d, got %0d", want.write_valid, rsp_write_valid);
               errors++;
            end
            if (rsp_gain_index !== want.gain_index) begin
               $error("gain_index: expected %0d, got %0d", want.gain_index, rsp_gain_index);
               errors++;
            end
            if (rsp_gain_value !== want.gain_value) begin
               $error("gain_value: expected %0d, got %0d",
                      $signed(want.gain_value), rsp_gain_value);
               errors++;
            end
            if (rsp_parse_error !== want.parse_error) begin
               $error("parse_error: expected %0d, got %0d", want.parse_error, rsp_parse_error);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
